// File: rtl/ptla_pkg.sv
// Shared types, sizes and codes of the presence table block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ptla_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KNOWN_DEPTH = 16;
    localparam int SEEN_BITS   = 256;

    localparam int ADDR_W   = 48;
    localparam int TIME_W   = 32;
    localparam int SIG_W    = 8;
    localparam int FLAG_W   = 4;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 6;

    localparam int TIDX_W       = $clog2(TABLE_DEPTH);
    localparam int TCNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KIDX_W       = (KNOWN_DEPTH > 1) ? $clog2(KNOWN_DEPTH) : 1;
    localparam int KCNT_W       = $clog2(KNOWN_DEPTH + 1);
    localparam int MAX_DEPTH    = (TABLE_DEPTH > KNOWN_DEPTH) ? TABLE_DEPTH : KNOWN_DEPTH;
    localparam int STEP_W       = $clog2(MAX_DEPTH + 1);
    localparam int SEEN_IDX_W   = $clog2(SEEN_BITS);
    localparam int SEEN_TOTAL_W = $clog2(SEEN_BITS + 1);

    // Hash runs over "aa:bb:cc:dd:ee:ff", one character per cycle.
    localparam int HASH_LEN   = 17;
    localparam int HASH_POS_W = 5;
    localparam logic [7:0] CHAR_COLON = 8'd58;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_MS        = 1'd1;
    localparam logic [SIG_W-1:0]  DEFAULT_THRESHOLD_RESET = 8'hBA; // -70
    localparam logic [TIME_W-1:0] TIMEOUT_RESET           = 32'd60000;

    // Flag bit positions.
    localparam int FL_ACTIVE = 0;
    localparam int FL_KNOWN  = 1;
    localparam int FL_NEAR   = 2;
    localparam int FL_WAS    = 3;

    localparam logic [ACTION_W-1:0] ACT_OBSERVE    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_KNOWN  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SWEEP      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SET_ACTIVE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_KNOWN_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] last_seen;
        logic [SIG_W-1:0]  rssi;
        logic [SIG_W-1:0]  thr;
        logic [FLAG_W-1:0] flags;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIG_W-1:0]  thr;
    } known_t;

endpackage
`default_nettype wire

// File: rtl/ptla_tcell.sv
// One table cell: holds one entry and passes it to its lower neighbor.
// Depends on ptla_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptla_tcell (
    input  wire logic            aclk,
    input  wire logic            shift_en,
    input  wire logic            wr_en,
    input  ptla_pkg::entry_t     nbr_in,
    input  ptla_pkg::entry_t     wr_data,
    output ptla_pkg::entry_t     q
);

    ptla_pkg::entry_t entry_reg;

    // A direct write wins over the shift.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg <= wr_data;
        end else if (shift_en) begin
            entry_reg <= nbr_in;
        end
    end

    assign q = entry_reg;

endmodule
`default_nettype wire

// File: rtl/ptla_kcell.sv
// One known-list cell: holds one known address and its threshold.
// Depends on ptla_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptla_kcell (
    input  wire logic            aclk,
    input  wire logic            shift_en,
    input  wire logic            wr_en,
    input  ptla_pkg::known_t     nbr_in,
    input  ptla_pkg::known_t     wr_data,
    output ptla_pkg::known_t     q
);

    ptla_pkg::known_t known_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            known_reg <= wr_data;
        end else if (shift_en) begin
            known_reg <= nbr_in;
        end
    end

    assign q = known_reg;

endmodule
`default_nettype wire

// File: rtl/ptla_hash.sv
// Serial base-31 hash over the colon text of an address, one char per cycle.
// Depends on ptla_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptla_hash (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [ptla_pkg::ADDR_W-1:0]     addr,
    output logic                                 done,
    output logic [ptla_pkg::SEEN_IDX_W-1:0]      hash_idx
);

    logic [ptla_pkg::ADDR_W-1:0]     sh_reg;
    logic [ptla_pkg::SEEN_IDX_W-1:0] h_reg;
    logic [ptla_pkg::HASH_POS_W-1:0] pos_reg;
    logic [1:0]                      sub_reg;
    logic [7:0]                      chr;
    logic                            run;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'd48 + {4'd0, nib}) : (8'd87 + {4'd0, nib});
    endfunction

    assign run = (pos_reg != ptla_pkg::HASH_POS_W'(ptla_pkg::HASH_LEN));

    always_comb begin
        case (sub_reg)
            2'd0:    chr = hex_char(sh_reg[ptla_pkg::ADDR_W-1 -: 4]);
            2'd1:    chr = hex_char(sh_reg[ptla_pkg::ADDR_W-5 -: 4]);
            default: chr = ptla_pkg::CHAR_COLON;
        endcase
    end

    // Only the low eight bits of the hash reach the map index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= ptla_pkg::HASH_POS_W'(ptla_pkg::HASH_LEN);
            sub_reg <= 2'd0;
        end else if (start) begin
            pos_reg <= '0;
            sub_reg <= 2'd0;
        end else if (run) begin
            pos_reg <= pos_reg + 1'b1;
            sub_reg <= (sub_reg == 2'd2) ? 2'd0 : sub_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg <= addr;
            h_reg  <= '0;
        end else if (run) begin
            h_reg <= (h_reg << 5) - h_reg + chr;
            if (sub_reg == 2'd1) begin
                sh_reg <= sh_reg << 8;
            end
        end
    end

    assign done     = !run && !start;
    assign hash_idx = h_reg;

endmodule
`default_nettype wire

// File: rtl/presence_table_with_lru_aging.sv
// Presence table: a row of entry cells and a row of known-address cells that
// rotate as queues, one entry past the head per cycle. A request is scanned over
// both rows while its address is hashed; an observation then appends one entry, or
// takes a second table pass to update or replace one, before the result loads into
// the output register. The next request is taken once the result has loaded.
// Synchronous active-low reset empties both lists, clears the seen map and restores defaults.
`timescale 1ns / 1ps
`default_nettype none
module presence_table_with_lru_aging (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [ptla_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ptla_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [ptla_pkg::ACTION_W-1:0]      s_action,
    input  wire logic [ptla_pkg::ADDR_W-1:0]        s_address,
    input  wire logic signed [ptla_pkg::SIG_W-1:0]  s_rssi,
    input  wire logic signed [ptla_pkg::SIG_W-1:0]  s_threshold,
    input  wire logic                               s_active_flag,
    input  wire logic [ptla_pkg::TIME_W-1:0]        s_now_ms,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [ptla_pkg::STATUS_W-1:0]           m_status,
    output logic [ptla_pkg::SLOT_W-1:0]             m_slot,
    output logic                                    m_is_known,
    output logic                                    m_is_nearby,
    output logic                                    m_was_nearby,
    output logic [ptla_pkg::SEEN_TOTAL_W-1:0]       m_ever_seen_total,
    output logic [ptla_pkg::COUNT_W-1:0]            m_active_count,
    output logic [ptla_pkg::COUNT_W-1:0]            m_present_count
);

    localparam int TD = ptla_pkg::TABLE_DEPTH;
    localparam int KD = ptla_pkg::KNOWN_DEPTH;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0; // wait for a request
    localparam logic [2:0] S_SCAN = 3'd1; // rotate both rows, hash, apply simple edits
    localparam logic [2:0] S_UPD  = 3'd2; // second table pass: rewrite one entry
    localparam logic [2:0] S_APP  = 3'd3; // append a new entry at the tail
    localparam logic [2:0] S_FIN  = 3'd4; // hand the result to the output register

    logic [2:0] state_reg, state_next;

    // Configuration registers.
    logic [ptla_pkg::SIG_W-1:0]  def_thr_reg;
    logic [ptla_pkg::TIME_W-1:0] timeout_reg;

    // Request held for the whole operation.
    logic [ptla_pkg::ACTION_W-1:0] action_reg;
    logic [ptla_pkg::ADDR_W-1:0]   addr_reg;
    logic [ptla_pkg::SIG_W-1:0]    rssi_reg;
    logic [ptla_pkg::SIG_W-1:0]    thr_reg;
    logic                          act_reg;
    logic [ptla_pkg::TIME_W-1:0]   now_reg;

    // List lengths, pass lengths and the pass step.
    logic [ptla_pkg::TCNT_W-1:0] tcnt_reg, tcnt_next;
    logic [ptla_pkg::KCNT_W-1:0] kcnt_reg, kcnt_next;
    logic [ptla_pkg::TCNT_W-1:0] tlim_reg;
    logic [ptla_pkg::KCNT_W-1:0] klim_reg;
    logic [ptla_pkg::STEP_W-1:0] step_reg;

    // Search results.
    logic                        emat_reg;
    logic [ptla_pkg::TIDX_W-1:0] eidx_reg;
    logic [ptla_pkg::TIME_W-1:0] oldest_reg;
    logic [ptla_pkg::TIDX_W-1:0] oidx_reg;
    logic                        kmat_reg;
    logic [ptla_pkg::KIDX_W-1:0] kidx_reg;
    logic [ptla_pkg::SIG_W-1:0]  kthr_reg;
    logic [ptla_pkg::TIDX_W-1:0] tidx_reg;

    // Counts and result fields.
    logic [ptla_pkg::TCNT_W-1:0]       ac_reg, pc_reg;
    logic [ptla_pkg::STATUS_W-1:0]     res_status_reg;
    logic [ptla_pkg::SLOT_W-1:0]       res_slot_reg;
    logic                              res_known_reg, res_near_reg, res_was_reg;
    logic [ptla_pkg::SEEN_BITS-1:0]    seen_reg;
    logic [ptla_pkg::SEEN_TOTAL_W-1:0] seen_total_reg;

    // Cell rows.
    ptla_pkg::entry_t tq [TD];
    ptla_pkg::known_t kq [KD];
    logic [TD-1:0]    twr;
    logic [KD-1:0]    kwr;
    ptla_pkg::entry_t twdata, hmod, obs_mod, obs_new;
    ptla_pkg::known_t kwdata, kmod;

    logic trun, krun, tshift, kshift, tkeep, kkeep, tapp, kapp;
    logic decide, tmatch, kmatch, timed, utouch, kfull, tfull, repl;
    logic hash_start, hash_done;
    logic [ptla_pkg::SEEN_IDX_W-1:0] hash_idx;

    // Apply an observation to an entry; a new entry starts from the defaults.
    function automatic ptla_pkg::entry_t obs_apply(
        input ptla_pkg::entry_t             base,
        input logic                         is_new,
        input logic [ptla_pkg::ADDR_W-1:0]  a,
        input logic [ptla_pkg::SIG_W-1:0]   r,
        input logic [ptla_pkg::TIME_W-1:0]  t,
        input logic                         known,
        input logic [ptla_pkg::SIG_W-1:0]   kthr,
        input logic [ptla_pkg::SIG_W-1:0]   dthr
    );
        ptla_pkg::entry_t e;
        e = base;
        if (is_new) begin
            e.addr  = a;
            e.flags = '0;
            e.thr   = dthr;
        end
        e.rssi      = r;
        e.last_seen = t;
        e.flags[ptla_pkg::FL_ACTIVE] = 1'b1;
        e.flags[ptla_pkg::FL_KNOWN]  = known;
        if (known) begin
            e.thr = kthr;
        end
        e.flags[ptla_pkg::FL_WAS]  = e.flags[ptla_pkg::FL_NEAR];
        e.flags[ptla_pkg::FL_NEAR] = ($signed(r) >= $signed(e.thr));
        return e;
    endfunction

    function automatic logic is_present(input ptla_pkg::entry_t e);
        is_present = e.flags[ptla_pkg::FL_ACTIVE] && e.flags[ptla_pkg::FL_KNOWN]
                     && ($signed(e.rssi) >= $signed(e.thr));
    endfunction

    // Accept a request only between operations; a waiting result does not block.
    assign s_ready = (state_reg == S_IDLE);

    assign trun   = (step_reg < ptla_pkg::STEP_W'(tlim_reg));
    assign krun   = (step_reg < ptla_pkg::STEP_W'(klim_reg));
    assign tshift = ((state_reg == S_SCAN) || (state_reg == S_UPD)) && trun;
    assign kshift = (state_reg == S_SCAN) && krun;
    assign decide = (state_reg == S_SCAN) && !trun && !krun && hash_done;
    assign tapp   = (state_reg == S_APP);
    assign kfull  = (kcnt_reg >= ptla_pkg::KCNT_W'(KD));
    assign tfull  = (tlim_reg == ptla_pkg::TCNT_W'(TD));
    assign kapp   = decide && (action_reg == ptla_pkg::ACT_ADD_KNOWN) && !kfull && !kmat_reg;

    assign tmatch = (tq[0].addr == addr_reg);
    assign kmatch = (kq[0].addr == addr_reg);
    assign timed  = ((now_reg - tq[0].last_seen) > timeout_reg);
    assign utouch = (state_reg == S_UPD) && trun
                    && (step_reg == ptla_pkg::STEP_W'(tidx_reg));
    // A replaced entry is rebuilt from scratch, like an appended one.
    assign repl   = (res_status_reg == ptla_pkg::ST_REPLACED);

    assign obs_mod = obs_apply(tq[0], repl, addr_reg, rssi_reg, now_reg,
                               kmat_reg, kthr_reg, def_thr_reg);
    assign obs_new = obs_apply(tq[0], 1'b1, addr_reg, rssi_reg, now_reg,
                               kmat_reg, kthr_reg, def_thr_reg);

    // Head of the table row: edit it as it goes round, or drop it.
    always_comb begin
        hmod  = tq[0];
        tkeep = 1'b1;
        if ((state_reg == S_SCAN) && trun) begin
            case (action_reg)
                ptla_pkg::ACT_SET_ACTIVE: begin
                    if (!emat_reg && tmatch) begin
                        hmod.flags[ptla_pkg::FL_ACTIVE] = act_reg;
                    end
                end
                ptla_pkg::ACT_SWEEP: begin
                    if (tq[0].flags[ptla_pkg::FL_ACTIVE] && timed) begin
                        if (tq[0].flags[ptla_pkg::FL_KNOWN]) begin
                            hmod.flags[ptla_pkg::FL_ACTIVE] = 1'b0;
                        end else begin
                            tkeep = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (utouch) begin
            hmod = obs_mod;
        end
    end

    // Head of the known row.
    always_comb begin
        kmod  = kq[0];
        kkeep = 1'b1;
        if (kshift && !kmat_reg && kmatch) begin
            case (action_reg)
                ptla_pkg::ACT_ADD_KNOWN: kmod.thr = thr_reg;
                ptla_pkg::ACT_REMOVE:    kkeep = 1'b0;
                default: begin
                end
            endcase
        end
    end

    // A kept head goes to the tail of the live part; an append lands just past it.
    assign twdata = tapp ? obs_new : hmod;
    assign kwdata = kapp ? ptla_pkg::known_t'{addr: addr_reg, thr: thr_reg} : kmod;

    for (genvar i = 0; i < TD; i++) begin : g_tcell
        ptla_pkg::entry_t nbr;
        if (i == TD - 1) begin : g_wrap
            assign nbr = tq[0];
        end else begin : g_mid
            assign nbr = tq[i+1];
        end
        assign twr[i] = (tshift && tkeep && (tcnt_reg == ptla_pkg::TCNT_W'(i + 1)))
                        || (tapp && (tcnt_reg == ptla_pkg::TCNT_W'(i)));
        ptla_tcell u_tcell (
            .aclk     (aclk),
            .shift_en (tshift),
            .wr_en    (twr[i]),
            .nbr_in   (nbr),
            .wr_data  (twdata),
            .q        (tq[i])
        );
    end

    for (genvar i = 0; i < KD; i++) begin : g_kcell
        ptla_pkg::known_t nbr;
        if (i == KD - 1) begin : g_wrap
            assign nbr = kq[0];
        end else begin : g_mid
            assign nbr = kq[i+1];
        end
        assign kwr[i] = (kshift && kkeep && (kcnt_reg == ptla_pkg::KCNT_W'(i + 1)))
                        || (kapp && (kcnt_reg == ptla_pkg::KCNT_W'(i)));
        ptla_kcell u_kcell (
            .aclk     (aclk),
            .shift_en (kshift),
            .wr_en    (kwr[i]),
            .nbr_in   (nbr),
            .wr_data  (kwdata),
            .q        (kq[i])
        );
    end

    assign hash_start = s_valid && s_ready;

    ptla_hash u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (hash_start),
        .addr     (s_address),
        .done     (hash_done),
        .hash_idx (hash_idx)
    );

    // List lengths: drop on a removed head, grow on an append.
    always_comb begin
        tcnt_next = tcnt_reg;
        kcnt_next = kcnt_reg;
        if (tshift && !tkeep) begin
            tcnt_next = tcnt_reg - 1'b1;
        end
        if (tapp) begin
            tcnt_next = tcnt_reg + 1'b1;
        end
        if (kshift && !kkeep) begin
            kcnt_next = kcnt_reg - 1'b1;
        end
        if (kapp) begin
            kcnt_next = kcnt_reg + 1'b1;
        end
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (decide) begin
                    if ((action_reg == ptla_pkg::ACT_OBSERVE) && (emat_reg || tfull)) begin
                        state_next = S_UPD;
                    end else if (action_reg == ptla_pkg::ACT_OBSERVE) begin
                        state_next = S_APP;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_UPD: begin
                if (!trun) begin
                    state_next = S_FIN;
                end
            end
            S_APP: state_next = S_FIN;
            S_FIN: begin
                if (!m_valid || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tcnt_reg       <= '0;
            kcnt_reg       <= '0;
            seen_reg       <= '0;
            seen_total_reg <= '0;
            def_thr_reg    <= ptla_pkg::DEFAULT_THRESHOLD_RESET;
            timeout_reg    <= ptla_pkg::TIMEOUT_RESET;
            m_valid        <= 1'b0;
        end else begin
            state_reg <= state_next;
            tcnt_reg  <= tcnt_next;
            kcnt_reg  <= kcnt_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    ptla_pkg::CFG_DEFAULT_THRESHOLD: def_thr_reg <= cfg_data[ptla_pkg::SIG_W-1:0];
                    ptla_pkg::CFG_TIMEOUT_MS:        timeout_reg <= cfg_data[ptla_pkg::TIME_W-1:0];
                    default: begin
                    end
                endcase
            end
            // Mark the address as ever seen once its hash is ready.
            if (decide && (action_reg == ptla_pkg::ACT_OBSERVE) && !seen_reg[hash_idx]) begin
                seen_reg[hash_idx] <= 1'b1;
                seen_total_reg     <= seen_total_reg + 1'b1;
            end
            if ((state_reg == S_FIN) && (!m_valid || m_ready)) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // Per-request datapath.
    always_ff @(posedge aclk) begin
        if (hash_start) begin
            action_reg     <= s_action;
            addr_reg       <= s_address;
            rssi_reg       <= s_rssi;
            thr_reg        <= s_threshold;
            act_reg        <= s_active_flag;
            now_reg        <= s_now_ms;
            step_reg       <= '0;
            tlim_reg       <= tcnt_reg;
            klim_reg       <= ((s_action == ptla_pkg::ACT_ADD_KNOWN) && kfull) ? '0 : kcnt_reg;
            emat_reg       <= 1'b0;
            eidx_reg       <= '0;
            kmat_reg       <= 1'b0;
            kidx_reg       <= '0;
            kthr_reg       <= '0;
            oldest_reg     <= '1;
            oidx_reg       <= '0;
            tidx_reg       <= '0;
            ac_reg         <= '0;
            pc_reg         <= '0;
            res_status_reg <= ptla_pkg::ST_UPDATED;
            res_slot_reg   <= '0;
            res_known_reg  <= 1'b0;
            res_near_reg   <= 1'b0;
            res_was_reg    <= 1'b0;
        end
        if (state_reg == S_SCAN) begin
            if (!decide) begin
                step_reg <= step_reg + 1'b1;
            end
            if (trun) begin
                if (!emat_reg && tmatch) begin
                    emat_reg <= 1'b1;
                    eidx_reg <= ptla_pkg::TIDX_W'(step_reg);
                end
                // Zero always wins, so the last zero stamp is the pick.
                if ((tq[0].last_seen == '0) || (tq[0].last_seen < oldest_reg)) begin
                    oldest_reg <= tq[0].last_seen;
                    oidx_reg   <= ptla_pkg::TIDX_W'(step_reg);
                end
            end
            if (krun && !kmat_reg && kmatch) begin
                kmat_reg <= 1'b1;
                kidx_reg <= ptla_pkg::KIDX_W'(step_reg);
                kthr_reg <= kq[0].thr;
            end
        end
        // Count what stays in the row on this pass.
        if (tshift && tkeep) begin
            ac_reg <= ac_reg + ptla_pkg::TCNT_W'(hmod.flags[ptla_pkg::FL_ACTIVE]);
            pc_reg <= pc_reg + ptla_pkg::TCNT_W'(is_present(hmod));
        end
        if (decide) begin
            case (action_reg)
                ptla_pkg::ACT_OBSERVE: begin
                    step_reg <= '0;
                    if (emat_reg) begin
                        tidx_reg       <= eidx_reg;
                        res_status_reg <= ptla_pkg::ST_UPDATED;
                        res_slot_reg   <= ptla_pkg::SLOT_W'(eidx_reg);
                        ac_reg         <= '0;
                        pc_reg         <= '0;
                    end else if (!tfull) begin
                        res_status_reg <= ptla_pkg::ST_NEW;
                        res_slot_reg   <= ptla_pkg::SLOT_W'(tcnt_reg);
                    end else begin
                        tidx_reg       <= oidx_reg;
                        res_status_reg <= ptla_pkg::ST_REPLACED;
                        res_slot_reg   <= ptla_pkg::SLOT_W'(oidx_reg);
                        ac_reg         <= '0;
                        pc_reg         <= '0;
                    end
                end
                ptla_pkg::ACT_ADD_KNOWN: begin
                    if (kfull) begin
                        res_status_reg <= ptla_pkg::ST_KNOWN_FULL;
                    end else if (kmat_reg) begin
                        res_slot_reg <= ptla_pkg::SLOT_W'(kidx_reg);
                    end else begin
                        res_status_reg <= ptla_pkg::ST_NEW;
                        res_slot_reg   <= ptla_pkg::SLOT_W'(kcnt_reg);
                    end
                end
                ptla_pkg::ACT_REMOVE: begin
                    if (kmat_reg) begin
                        res_slot_reg <= ptla_pkg::SLOT_W'(kidx_reg);
                    end else begin
                        res_status_reg <= ptla_pkg::ST_NOT_FOUND;
                    end
                end
                ptla_pkg::ACT_SET_ACTIVE: begin
                    if (emat_reg) begin
                        res_slot_reg <= ptla_pkg::SLOT_W'(eidx_reg);
                    end else begin
                        res_status_reg <= ptla_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                end
            endcase
        end
        if (state_reg == S_UPD) begin
            step_reg <= step_reg + 1'b1;
        end
        if (utouch) begin
            res_known_reg <= obs_mod.flags[ptla_pkg::FL_KNOWN];
            res_near_reg  <= obs_mod.flags[ptla_pkg::FL_NEAR];
            res_was_reg   <= obs_mod.flags[ptla_pkg::FL_WAS];
        end
        if (tapp) begin
            res_known_reg <= obs_new.flags[ptla_pkg::FL_KNOWN];
            res_near_reg  <= obs_new.flags[ptla_pkg::FL_NEAR];
            res_was_reg   <= obs_new.flags[ptla_pkg::FL_WAS];
            ac_reg        <= ac_reg + 1'b1;
            pc_reg        <= pc_reg + ptla_pkg::TCNT_W'(is_present(obs_new));
        end
    end

    // Output register: load on finish, hold while the consumer stalls.
    always_ff @(posedge aclk) begin
        if ((state_reg == S_FIN) && (!m_valid || m_ready)) begin
            m_status          <= res_status_reg;
            m_slot            <= res_slot_reg;
            m_is_known        <= res_known_reg;
            m_is_nearby       <= res_near_reg;
            m_was_nearby      <= res_was_reg;
            m_ever_seen_total <= seen_total_reg;
            m_active_count    <= ptla_pkg::COUNT_W'(ac_reg);
            m_present_count   <= ptla_pkg::COUNT_W'(pc_reg);
        end
    end

endmodule
`default_nettype wire

// File: rtl/ptla_checker.sv
// Port-level checks of the presence table, bound to its top level.
// Depends on ptla_pkg and presence_table_with_lru_aging.
`timescale 1ns / 1ps
`default_nettype none
module ptla_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire logic [ptla_pkg::STATUS_W-1:0]      m_status,
    input  wire logic [ptla_pkg::SLOT_W-1:0]        m_slot,
    input  wire logic [ptla_pkg::COUNT_W-1:0]       m_active_count,
    input  wire logic [ptla_pkg::COUNT_W-1:0]       m_present_count
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_slot) && $stable(m_status))
        else $error("result changed while stalled");

    a_present_le_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_present_count <= m_active_count)
                    && (m_active_count <= ptla_pkg::COUNT_W'(ptla_pkg::TABLE_DEPTH)))
        else $error("present count exceeds active count");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ptla_pkg::ST_UPDATED) || (m_status == ptla_pkg::ST_NEW)
                    || (m_status == ptla_pkg::ST_REPLACED)
                    || (m_status == ptla_pkg::ST_KNOWN_FULL)
                    || (m_status == ptla_pkg::ST_NOT_FOUND))
        else $error("unexpected status code");

endmodule

bind presence_table_with_lru_aging ptla_checker u_ptla_checker (.*);
`default_nettype wire
